### rtl/kre_pkg.sv
// Package for the keyboard report differ: sizes, HID codes, event slot
// layout and the job record that travels from front to back.
// No dependencies.
package kre_pkg;

  // Key slots of one boot report (fixed by the report format)
  localparam int KEY_SLOTS = 6;

  // Modifier events: Shift, Ctrl, Alt, each release then press
  localparam int MOD_EVENTS = 6;
  localparam int NUM_EVENTS = MOD_EVENTS + 2 * KEY_SLOTS;

  // Default depth of the job queue between front and back
  localparam int QUEUE_DEPTH_DEF = 2;

  // HID usage codes used for modifier events
  localparam logic [7:0] CODE_CTRL  = 8'hE0;
  localparam logic [7:0] CODE_SHIFT = 8'hE1;
  localparam logic [7:0] CODE_ALT   = 8'hE2;

  // Left and right bits of each modifier kind
  localparam logic [7:0] MASK_CTRL  = 8'h11;
  localparam logic [7:0] MASK_SHIFT = 8'h22;
  localparam logic [7:0] MASK_ALT   = 8'h44;

  // Positions of the modifier events in the pending mask
  localparam int EV_SHIFT_REL = 0;
  localparam int EV_SHIFT_PRS = 1;
  localparam int EV_CTRL_REL  = 2;
  localparam int EV_CTRL_PRS  = 3;
  localparam int EV_ALT_REL   = 4;
  localparam int EV_ALT_PRS   = 5;
  // Key releases start here, key presses follow them
  localparam int EV_KEY_REL   = MOD_EVENTS;
  localparam int EV_KEY_PRS   = MOD_EVENTS + KEY_SLOTS;

  typedef logic [7:0]            keycode_t;
  typedef keycode_t [KEY_SLOTS-1:0] key_row_t;
  typedef logic [NUM_EVENTS-1:0] ev_mask_t;

  // One classified report: which events remain, plus the codes they need
  typedef struct packed {
    ev_mask_t mask;
    key_row_t old_keys;
    key_row_t new_keys;
  } kre_job_t;

  // Bits of the pending mask that stand for press events
  function automatic ev_mask_t press_positions();
    ev_mask_t m;
    m = '0;
    for (int j = 0; j < NUM_EVENTS; j++) begin
      if (j < MOD_EVENTS) begin
        m[j] = (j % 2) == 1;
      end else begin
        m[j] = j >= EV_KEY_PRS;
      end
    end
    return m;
  endfunction

  localparam ev_mask_t PRESS_MASK = press_positions();

endpackage

### rtl/kre_if.sv
// Handshake channels of the keyboard report differ: the report channel
// and the key event channel. No dependencies.
interface kre_report_if;
  logic       valid;
  logic       ready;
  logic [7:0] modifier_bits;
  logic [7:0] key_0;
  logic [7:0] key_1;
  logic [7:0] key_2;
  logic [7:0] key_3;
  logic [7:0] key_4;
  logic [7:0] key_5;

  modport source (output valid, modifier_bits, key_0, key_1, key_2, key_3, key_4, key_5,
                  input ready);
  modport sink   (input valid, modifier_bits, key_0, key_1, key_2, key_3, key_4, key_5,
                  output ready);
endinterface

interface kre_event_if;
  logic       valid;
  logic       ready;
  logic [7:0] event_keycode;
  logic       is_press;
  logic       last_event;

  modport source (output valid, event_keycode, is_press, last_event, input ready);
  modport sink   (input valid, event_keycode, is_press, last_event, output ready);
endinterface

### rtl/kre_front.sv
// Front part: takes reports, diffs them against the stored previous
// report and hands a job with its pending event mask to the queue.
// Depends on kre_pkg and kre_if.
module kre_front
  import kre_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  kre_report_if.sink        rpt,
  output logic              push_valid,
  input  logic              push_ready,
  output kre_job_t          push_job
);

  logic [7:0] prev_mods;
  key_row_t   prev_keys;
  key_row_t   new_keys;
  logic [7:0] rel_bits;
  logic [7:0] prs_bits;
  ev_mask_t   mask;
  logic       accept;

  // Report slots as a row
  assign new_keys[0] = rpt.key_0;
  assign new_keys[1] = rpt.key_1;
  assign new_keys[2] = rpt.key_2;
  assign new_keys[3] = rpt.key_3;
  assign new_keys[4] = rpt.key_4;
  assign new_keys[5] = rpt.key_5;

  assign rel_bits = prev_mods & ~rpt.modifier_bits;
  assign prs_bits = rpt.modifier_bits & ~prev_mods;

  // Classify: one mask bit per event this report causes
  always_comb begin
    logic hit;
    mask = '0;
    mask[EV_SHIFT_REL] = |(rel_bits & MASK_SHIFT);
    mask[EV_SHIFT_PRS] = |(prs_bits & MASK_SHIFT);
    mask[EV_CTRL_REL]  = |(rel_bits & MASK_CTRL);
    mask[EV_CTRL_PRS]  = |(prs_bits & MASK_CTRL);
    mask[EV_ALT_REL]   = |(rel_bits & MASK_ALT);
    mask[EV_ALT_PRS]   = |(prs_bits & MASK_ALT);
    for (int i = 0; i < KEY_SLOTS; i++) begin
      // old key gone from the new report
      hit = 1'b0;
      for (int k = 0; k < KEY_SLOTS; k++) begin
        hit = hit | (new_keys[k] == prev_keys[i]);
      end
      mask[EV_KEY_REL + i] = (prev_keys[i] != '0) && !hit;
      // new key not in the old report
      hit = 1'b0;
      for (int k = 0; k < KEY_SLOTS; k++) begin
        hit = hit | (prev_keys[k] == new_keys[i]);
      end
      mask[EV_KEY_PRS + i] = (new_keys[i] != '0) && !hit;
    end
  end

  // Reports with no change are absorbed without a job
  assign rpt.ready  = push_ready;
  assign accept     = rpt.valid && push_ready;
  assign push_valid = accept && (mask != '0);

  assign push_job.mask     = mask;
  assign push_job.old_keys = prev_keys;
  assign push_job.new_keys = new_keys;

  // Previous report
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_mods <= '0;
      prev_keys <= '0;
    end else if (accept) begin
      prev_mods <= rpt.modifier_bits;
      prev_keys <= new_keys;
    end
  end

endmodule

### rtl/kre_queue.sv
// Short job queue between the front and back parts.
// Depends on kre_pkg.
module kre_queue
  import kre_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  kre_job_t in_job,
  output logic     out_valid,
  input  logic     out_ready,
  output kre_job_t out_job
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  kre_job_t      mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          push;
  logic          pop;

  assign in_ready  = count != FULL_CNT;
  assign out_valid = count != '0;
  assign out_job   = mem[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_job;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### rtl/kre_back.sv
// Back part: walks the pending mask of the current job lowest bit first
// and drives one key event per cycle into the output register unless evt.ready stalls it.
// Depends on kre_pkg and kre_if.
module kre_back
  import kre_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       job_valid,
  output logic       job_ready,
  input  kre_job_t   job,
  kre_event_if.source evt,
  output logic       busy
);

  logic     cur_valid;
  ev_mask_t cur_mask;
  key_row_t cur_old;
  key_row_t cur_new;
  ev_mask_t sel;
  ev_mask_t rest;
  keycode_t code;
  logic     advance;
  logic     finish;
  logic     load;

  // Lowest pending event, one-hot
  assign sel  = cur_mask & (~cur_mask + 1'b1);
  assign rest = cur_mask & ~sel;

  // Keycode of the selected event
  always_comb begin
    code = '0;
    if (sel[EV_SHIFT_REL] || sel[EV_SHIFT_PRS]) code = code | CODE_SHIFT;
    if (sel[EV_CTRL_REL]  || sel[EV_CTRL_PRS])  code = code | CODE_CTRL;
    if (sel[EV_ALT_REL]   || sel[EV_ALT_PRS])   code = code | CODE_ALT;
    for (int i = 0; i < KEY_SLOTS; i++) begin
      if (sel[EV_KEY_REL + i]) code = code | cur_old[i];
      if (sel[EV_KEY_PRS + i]) code = code | cur_new[i];
    end
  end

  assign advance   = cur_valid && (!evt.valid || evt.ready);
  assign finish    = advance && (rest == '0);
  assign load      = job_valid && (!cur_valid || finish);
  assign job_ready = load;
  assign busy      = cur_valid;

  // Current job
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
    end else if (load) begin
      cur_valid <= 1'b1;
    end else if (finish) begin
      cur_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur_mask <= job.mask;
      cur_old  <= job.old_keys;
      cur_new  <= job.new_keys;
    end else if (advance) begin
      cur_mask <= rest;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      evt.valid <= 1'b0;
    end else if (advance) begin
      evt.valid <= 1'b1;
    end else if (evt.ready) begin
      evt.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      evt.event_keycode <= code;
      evt.is_press      <= |(sel & PRESS_MASK);
      evt.last_event    <= rest == '0;
    end
  end

endmodule

### rtl/keyboard_report_to_key_events_core.sv
// Top level of the keyboard report differ: front, job queue, back.
// Depends on kre_pkg, kre_if, kre_front, kre_queue, kre_back.
//
//   channel  dir  handshake          payload
//   rpt      in   rpt.valid/ready    modifier_bits, key_0 .. key_5
//   evt      out  evt.valid/ready    event_keycode, is_press, last_event
//
// A report yields 0 to 18 events, one per cycle unless evt.ready is low.
// The event output rate is bounded by the single-event-per-cycle back part.
// Reports with no change produce nothing.
// Up to QUEUE_DEPTH diffed reports wait between front and back; rpt.ready
// drops only when that queue is full. Reset clears the stored report.
module keyboard_report_to_key_events_core
  import kre_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  kre_report_if.sink  rpt,
  kre_event_if.source evt
);

  logic     f_valid;
  logic     f_ready;
  kre_job_t f_job;
  logic     q_valid;
  logic     q_ready;
  kre_job_t q_job;
  logic     back_busy;

  kre_front u_front (
    .clk        (clk),
    .rst        (rst),
    .rpt        (rpt),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_job   (f_job)
  );

  kre_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_job    (f_job),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_job   (q_job)
  );

  kre_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (q_valid),
    .job_ready (q_ready),
    .job       (q_job),
    .evt       (evt),
    .busy      (back_busy)
  );

  // Queued jobs always carry at least one event
  a_job_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_valid |-> (q_job.mask != '0))
    else $error("empty job in queue");

  // Reset leaves no event and no job pending
  a_reset_clear: assert property (@(posedge clk)
    rst |=> (!evt.valid && !q_valid && !back_busy))
    else $error("state not cleared by reset");

  // With the back idle, a shown event must close its report
  a_last_when_idle: assert property (@(posedge clk) disable iff (rst)
    (evt.valid && !back_busy) |-> evt.last_event)
    else $error("non-final event with no job in progress");

endmodule

### verif/tb_keyboard_report_to_key_events_core.sv
// Testbench for keyboard_report_to_key_events_core: drives boot keyboard reports,
// predicts the key events of each report and checks them in order.
// Depends on kre_pkg, kre_if and the RTL of the core.
module tb_keyboard_report_to_key_events_core;
  import kre_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_REPORTS = 430;
  localparam int unsigned HOLD_AT        = 60;   // receiver holds off from here
  localparam int unsigned HOLD_ITEMS     = 20;   // back-to-back reports during the hold
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned PAUSE_AT       = 240;  // sender waits for every event here
  localparam int unsigned IDLE_LIMIT     = 4000;
  localparam int unsigned DRAIN_CYCLES   = 40;
  localparam int          NUM_DIRECTED   = 21;

  localparam logic PRESS   = 1'b1;
  localparam logic RELEASE = 1'b0;
  localparam logic LAST    = 1'b1;
  localparam logic MORE    = 1'b0;

  typedef keycode_t key_slots_t [KEY_SLOTS];

  typedef struct packed {
    keycode_t code;
    logic     press;
    logic     last;
  } key_event_t;

  localparam key_event_t NO_EVENT = '0;

  // One report to send; typed rows carry their events written out by hand
  typedef struct {
    keycode_t    mods;
    key_slots_t  k;
    bit          typed;
    int unsigned n;
    key_event_t  ev [2];
  } dir_row_t;

  typedef enum {EDIT_MOD, EDIT_PUT, EDIT_CLEAR, EDIT_SWAP, EDIT_COPY} edit_t;

  // Modifier kinds in event order
  localparam keycode_t KIND_MASK [3] = '{MASK_SHIFT, MASK_CTRL, MASK_ALT};
  localparam keycode_t KIND_CODE [3] = '{CODE_SHIFT, CODE_CTRL, CODE_ALT};

  logic clk = 1'b0;
  logic rst;

  kre_report_if rpt_ch();
  kre_event_if  evt_ch();

  keyboard_report_to_key_events_core uut (
    .clk(clk),
    .rst(rst),
    .rpt(rpt_ch),
    .evt(evt_ch)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Directed reports: extremes, each modifier kind, duplicates, GUI bits,
  // no change, and a report with the largest number of events
  dir_row_t directed_rows [NUM_DIRECTED] = '{
    '{8'h00, '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1, 0,
      '{NO_EVENT, NO_EVENT}},
    '{8'h02, '{8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1, 2,
      '{'{CODE_SHIFT, PRESS, MORE}, '{8'h04, PRESS, LAST}}},
    '{8'h02, '{8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1, 0,
      '{NO_EVENT, NO_EVENT}},
    // left shift let go while right shift goes down
    '{8'h20, '{8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1, 2,
      '{'{CODE_SHIFT, RELEASE, MORE}, '{CODE_SHIFT, PRESS, LAST}}},
    '{8'h77, '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF}, 1'b0, 0,
      '{NO_EVENT, NO_EVENT}},
    '{8'h88, '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, 0,
      '{NO_EVENT, NO_EVENT}},
    // GUI bits alone never make events
    '{8'h88, '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1, 0,
      '{NO_EVENT, NO_EVENT}},
    '{8'h00, '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1, 0,
      '{NO_EVENT, NO_EVENT}},
    '{8'hFF, '{8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06}, 1'b0, 0,
      '{NO_EVENT, NO_EVENT}},
    // same keys in another order: modifier releases only
    '{8'h00, '{8'h06, 8'h05, 8'h04, 8'h03, 8'h02, 8'h01}, 1'b0, 0,
      '{NO_EVENT, NO_EVENT}},
    '{8'h00, '{8'h01, 8'h01, 8'h07, 8'h00, 8'h00, 8'h00}, 1'b0, 0,
      '{NO_EVENT, NO_EVENT}},
    '{8'h00, '{8'h08, 8'h08, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, 0,
      '{NO_EVENT, NO_EVENT}},
    '{8'h00, '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, 0,
      '{NO_EVENT, NO_EVENT}},
    // both ctrl bits together give one press
    '{8'h11, '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1, 1,
      '{'{CODE_CTRL, PRESS, LAST}, NO_EVENT}},
    '{8'h10, '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1, 1,
      '{'{CODE_CTRL, RELEASE, LAST}, NO_EVENT}},
    '{8'h01, '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1, 2,
      '{'{CODE_CTRL, RELEASE, MORE}, '{CODE_CTRL, PRESS, LAST}}},
    '{8'h04, '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1, 2,
      '{'{CODE_CTRL, RELEASE, MORE}, '{CODE_ALT, PRESS, LAST}}},
    '{8'h40, '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1, 2,
      '{'{CODE_ALT, RELEASE, MORE}, '{CODE_ALT, PRESS, LAST}}},
    // left set to right set with disjoint keys: every event slot used
    '{8'h07, '{8'h10, 8'h11, 8'h12, 8'h13, 8'h14, 8'h15}, 1'b0, 0,
      '{NO_EVENT, NO_EVENT}},
    '{8'h70, '{8'h20, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25}, 1'b0, 0,
      '{NO_EVENT, NO_EVENT}},
    '{8'h00, '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, 0,
      '{NO_EVENT, NO_EVENT}}
  };

  // Predictor state: the report seen last
  keycode_t   held_mods = '0;
  key_slots_t held_keys = '{default: '0};

  dir_row_t    report_plans [$];
  key_event_t  pending_events [$];
  int unsigned mismatch_count = 0;
  int unsigned reports_seen   = 0;
  int unsigned quiet_reports  = 0;
  int unsigned events_checked = 0;
  int unsigned most_events    = 0;
  int unsigned idle_cycles    = 0;
  bit          hold_req       = 1'b0;

  logic report_taken, event_taken;
  assign report_taken = rpt_ch.valid === 1'b1 && rpt_ch.ready === 1'b1;
  assign event_taken  = evt_ch.valid === 1'b1 && evt_ch.ready === 1'b1;

  function automatic bit slot_holds(input key_slots_t row, input keycode_t code);
    foreach (row[i]) begin
      if (row[i] == code) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Key events of one report against the held one; the report is then held
  function automatic void diff_report(input keycode_t mods, input key_slots_t keys,
                                      output key_event_t evs [$]);
    keycode_t gone_mods, new_mods;
    evs = {};
    gone_mods = held_mods & ~mods;
    new_mods  = mods & ~held_mods;
    for (int j = 0; j < 3; j++) begin
      if ((gone_mods & KIND_MASK[j]) != '0) evs.push_back('{KIND_CODE[j], RELEASE, MORE});
      if ((new_mods & KIND_MASK[j]) != '0) evs.push_back('{KIND_CODE[j], PRESS, MORE});
    end
    foreach (held_keys[i]) begin
      if (held_keys[i] != '0 && !slot_holds(keys, held_keys[i]))
        evs.push_back('{held_keys[i], RELEASE, MORE});
    end
    foreach (keys[i]) begin
      if (keys[i] != '0 && !slot_holds(held_keys, keys[i]))
        evs.push_back('{keys[i], PRESS, MORE});
    end
    if (evs.size() > 0) evs[evs.size()-1].last = LAST;
    held_mods = mods;
    held_keys = keys;
  endfunction

  // Mostly short gaps, some none, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Next report: mostly small edits of the last one, like a typist would
  // make, with some fully random reports, some all-up reports and repeats
  function automatic dir_row_t next_row(input dir_row_t cur);
    dir_row_t    nxt;
    int unsigned mode, r;
    logic [2:0]  a, b, bitpos;
    keycode_t    tmp;
    nxt = cur;
    nxt.typed = 1'b0;
    nxt.n = 0;
    mode = $urandom_range(0, 99);
    if (mode < 10) begin
      nxt.mods = 8'($urandom);
      foreach (nxt.k[i]) nxt.k[i] = 8'($urandom);
    end else if (mode < 14) begin
      nxt.mods = '0;
      foreach (nxt.k[i]) nxt.k[i] = '0;
    end else if (mode >= 20) begin
      repeat ($urandom_range(1, 3)) begin
        a = 3'($urandom_range(0, KEY_SLOTS-1));
        b = 3'($urandom_range(0, KEY_SLOTS-1));
        bitpos = 3'($urandom_range(0, 7));
        case (edit_t'($urandom_range(0, 4)))
          EDIT_MOD: nxt.mods[bitpos] = ~nxt.mods[bitpos];
          EDIT_PUT: begin
            r = $urandom_range(0, 99);
            if (r < 50) nxt.k[a] = 8'($urandom_range(4, 11));
            else if (r < 80) nxt.k[a] = 8'($urandom_range(4, 101));
            else nxt.k[a] = 8'($urandom_range(0, 255));
          end
          EDIT_CLEAR: nxt.k[a] = '0;
          EDIT_SWAP: begin
            tmp = nxt.k[a];
            nxt.k[a] = nxt.k[b];
            nxt.k[b] = tmp;
          end
          EDIT_COPY: nxt.k[b] = nxt.k[a];
          default: ;
        endcase
      end
    end
    return nxt;
  endfunction

  task automatic offer_report(input dir_row_t row);
    report_plans.push_back(row);
    rpt_ch.valid         <= 1'b1;
    rpt_ch.modifier_bits <= row.mods;
    rpt_ch.key_0         <= row.k[0];
    rpt_ch.key_1         <= row.k[1];
    rpt_ch.key_2         <= row.k[2];
    rpt_ch.key_3         <= row.k[3];
    rpt_ch.key_4         <= row.k[4];
    rpt_ch.key_5         <= row.k[5];
    do @(posedge clk); while (!report_taken);
  endtask

  task automatic pause_sender(input int unsigned gap);
    if (gap > 0) begin
      rpt_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Report side
  initial begin
    dir_row_t    cur;
    int unsigned gap;
    rst                  = 1'b1;
    rpt_ch.valid         = 1'b0;
    rpt_ch.modifier_bits = '0;
    rpt_ch.key_0         = '0;
    rpt_ch.key_1         = '0;
    rpt_ch.key_2         = '0;
    rpt_ch.key_3         = '0;
    rpt_ch.key_4         = '0;
    rpt_ch.key_5         = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      offer_report(directed_rows[i]);
      pause_sender(pick_gap());
    end

    cur = directed_rows[NUM_DIRECTED-1];
    for (int unsigned n = 0; n < RANDOM_REPORTS; n++) begin
      if (n == HOLD_AT) hold_req = 1'b1;
      // wait for every event before going on
      if (n == PAUSE_AT) begin
        rpt_ch.valid <= 1'b0;
        do @(posedge clk); while (pending_events.size() != 0);
      end
      cur = next_row(cur);
      offer_report(cur);
      if ((n % 64) < 16 || (n >= HOLD_AT && n < HOLD_AT + HOLD_ITEMS)) gap = 0;
      else gap = pick_gap();
      pause_sender(gap);
    end
    rpt_ch.valid <= 1'b0;

    do @(posedge clk); while (pending_events.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d reports (%0d with no events) and %0d key events, up to %0d per report",
             reports_seen, quiet_reports, events_checked, most_events);
    if (mismatch_count == 0) begin
      $display("keyboard_report_to_key_events_core test passed");
    end else begin
      $display("keyboard_report_to_key_events_core test failed");
    end
    $finish;
  end

  // Event side: random stalls, and one long hold-off on request
  initial begin
    int unsigned run, gap;
    evt_ch.ready = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_req) begin
        evt_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      evt_ch.ready <= 1'b1;
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 8);
      repeat (run) begin
        @(posedge clk);
        if (hold_req) break;
      end
      gap = pick_gap();
      if (gap > 0 && !hold_req) begin
        evt_ch.ready <= 1'b0;
        repeat (gap) begin
          @(posedge clk);
          if (hold_req) break;
        end
      end
    end
  end

  // Predict on each accepted report, check each accepted event
  always @(posedge clk) begin : monitor
    key_slots_t  seen;
    key_event_t  evs [$];
    key_event_t  want;
    dir_row_t    plan;
    if (!rst) begin
      if (report_taken) begin
        seen = '{rpt_ch.key_0, rpt_ch.key_1, rpt_ch.key_2,
                 rpt_ch.key_3, rpt_ch.key_4, rpt_ch.key_5};
        plan = report_plans.pop_front();
        diff_report(rpt_ch.modifier_bits, seen, evs);
        if (plan.typed) begin
          evs = {};
          for (int j = 0; j < plan.n; j++) evs.push_back(plan.ev[j]);
        end
        foreach (evs[j]) pending_events.push_back(evs[j]);
        reports_seen++;
        if (evs.size() == 0) quiet_reports++;
        if (evs.size() > most_events) most_events = evs.size();
      end
      if (event_taken) begin
        if (pending_events.size() == 0) begin
          $error("event with nothing expected: keycode %h press %b last %b",
                 evt_ch.event_keycode, evt_ch.is_press, evt_ch.last_event);
          mismatch_count++;
        end else begin
          want = pending_events.pop_front();
          events_checked++;
          if (evt_ch.event_keycode !== want.code) begin
            $error("event_keycode: expected %h, got %h", want.code, evt_ch.event_keycode);
            mismatch_count++;
          end
          if (evt_ch.is_press !== want.press) begin
            $error("is_press: expected %b, got %b", want.press, evt_ch.is_press);
            mismatch_count++;
          end
          if (evt_ch.last_event !== want.last) begin
            $error("last_event: expected %b, got %b", want.last, evt_ch.last_event);
            mismatch_count++;
          end
        end
      end
    end
  end

  // Watchdog: ends the run when no item moves for too long
  always @(posedge clk) begin
    if (rst || report_taken || event_taken) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $error("no item moved for %0d cycles, %0d events still expected",
               idle_cycles, pending_events.size());
        $display("keyboard_report_to_key_events_core test failed");
        $finish;
      end
    end
  end

endmodule

### keyboard_report_to_key_events_core.f
rtl/kre_pkg.sv
rtl/kre_if.sv
rtl/kre_front.sv
rtl/kre_queue.sv
rtl/kre_back.sv
rtl/keyboard_report_to_key_events_core.sv
verif/tb_keyboard_report_to_key_events_core.sv
